### hw/rtl/ahfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ahfr_pkg
// Shared types, constants and the CRC-16/CCITT step of the HDLC receiver.
// ----------------------------------------------------------------------------
package ahfr_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [7:0]  FLAG_OCTET = 8'h7E;
    localparam logic [7:0]  ESC_OCTET  = 8'h7D;
    localparam logic [7:0]  FLIP_BIT   = 8'h20;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    typedef enum logic [1:0] {
        CMD_FEED    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LATCHED  = 2'd1,
        ST_REJECT   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } ahfr_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } ahfr_result_t;

    // Reflected CRC-16, one byte.
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ahfr_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ahfr_deframer
// Receiver state, frame store and result register. One item per step.
// ----------------------------------------------------------------------------
module ahfr_deframer
    import ahfr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire ahfr_item_t   item,
    output      ahfr_result_t result
);

    logic [7:0]        store_mem [STORE_DEPTH];

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic              esc_reg, esc_next;
    logic              ready_reg, ready_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        last_reg, last_next;
    logic [7:0]        second_reg, second_next;

    logic [1:0]        status_reg, status_next;
    logic              rdy_out_reg;
    logic [7:0]        len_out_reg;
    logic [7:0]        rd_mem_reg;
    logic              rd_sel_reg, rd_sel_next;

    logic              wr_en;
    logic [7:0]        wr_data;
    logic [7:0]        d;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  pos_m2;
    logic [ADDR_W-1:0] rd_addr;

    assign pos_inc = pos_reg + 1'b1;
    assign pos_m2  = pos_reg - POS_W'(2);
    assign rd_addr = ADDR_W'(item.read_index);

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        esc_next    = esc_reg;
        ready_next  = ready_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        second_next = second_reg;
        status_next = ST_OK;
        rd_sel_next = 1'b0;
        wr_en       = 1'b0;
        wr_data     = item.rx_byte;
        d           = item.rx_byte;

        case (cmd_t'(item.command))
            CMD_FEED:
            begin
                if (ready_reg)
                begin
                    status_next = ST_REJECT;
                end
                else if (item.rx_byte == FLAG_OCTET)
                begin
                    esc_next = 1'b0;
                    pos_next = '0;
                    crc_next = CRC_INIT;
                    if (!esc_reg && pos_reg >= POS_W'(2) &&
                        crc_reg == {last_reg, second_reg})
                    begin
                        ready_next  = 1'b1;
                        len_next    = (32'(pos_m2) > 32'd255) ? 8'hFF : 8'(pos_m2);
                        status_next = ST_LATCHED;
                    end
                end
                else if (!esc_reg && item.rx_byte == ESC_OCTET)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    if (esc_reg)
                        d = item.rx_byte ^ FLIP_BIT;
                    esc_next    = 1'b0;
                    wr_en       = 1'b1;
                    wr_data     = d;
                    // CRC trails the write position by two bytes
                    if (pos_reg >= POS_W'(2))
                        crc_next = crc_step(crc_reg, second_reg);
                    second_next = last_reg;
                    last_next   = d;
                    pos_next    = pos_inc;
                    if (pos_inc >= POS_W'(STORE_DEPTH))
                    begin
                        pos_next    = '0;
                        crc_next    = CRC_INIT;
                        status_next = ST_OVERFLOW;
                    end
                end
            end
            CMD_READ:
            begin
                rd_sel_next = (32'(item.read_index) < 32'(STORE_DEPTH));
            end
            CMD_RELEASE:
            begin
                pos_next   = '0;
                crc_next   = CRC_INIT;
                esc_next   = 1'b0;
                ready_next = 1'b0;
                len_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            crc_reg    <= CRC_INIT;
            esc_reg    <= 1'b0;
            ready_reg  <= 1'b0;
            len_reg    <= '0;
            last_reg   <= '0;
            second_reg <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            esc_reg    <= esc_next;
            ready_reg  <= ready_next;
            len_reg    <= len_next;
            last_reg   <= last_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
            store_mem[pos_reg[ADDR_W-1:0]] <= wr_data;
    end

    // result register, held while the downstream side stalls
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rd_mem_reg  <= store_mem[rd_addr];
            rd_sel_reg  <= rd_sel_next;
            status_reg  <= status_next;
            rdy_out_reg <= ready_next;
            len_out_reg <= ready_next ? len_next : 8'h00;
        end
    end

    assign result.status       = status_reg;
    assign result.frame_ready  = rdy_out_reg;
    assign result.frame_length = len_out_reg;
    assign result.read_data    = rd_sel_reg ? rd_mem_reg : 8'h00;

endmodule
`default_nettype wire

### hw/rtl/async_hdlc_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// async_hdlc_frame_receiver
// Byte-stuffed HDLC deframer with CRC-16/CCITT check and a readable frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall): command, rx_byte, read_index. Feed
//   sends one line byte, read fetches a stored byte, release clears the
//   receiver so the next frame can be taken.
//   Result channel (result_valid/result_stall): status, frame_ready,
//   frame_length, read_data; exactly one result per transaction.
//   Flow: the accepting edge loads the input register; state update plus
//   store access land in the result register when the item advances, which
//   waits while result_stall holds a valid result.
//   Throughput: one item per cycle unless stalled; the store is written and
//   read in the same single-pass stage, so a read sees every earlier feed.
//   Reset clears position, CRC, escape and the ready latch; store contents are
//   undefined until written.
//   When result_stall holds a valid result, the result register freezes, the
//   input register fills, and item_stall holds off the sender while it is full.
// ----------------------------------------------------------------------------
module async_hdlc_frame_receiver
    import ahfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output      logic       item_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] read_index,
    output      logic       result_valid,
    input  wire logic       result_stall,
    output      logic [1:0] status,
    output      logic       frame_ready,
    output      logic [7:0] frame_length,
    output      logic [7:0] read_data
);

    ahfr_item_t   item_reg;
    logic         item_vld_reg, item_vld_next;
    logic         res_vld_reg, res_vld_next;
    logic         advance;
    logic         accept;
    ahfr_result_t result;

    assign advance       = item_vld_reg && (!res_vld_reg || !result_stall);
    assign item_stall    = item_vld_reg && !advance;
    assign accept        = item_valid && !item_stall;
    assign item_vld_next = accept || (item_vld_reg && !advance);
    assign res_vld_next  = advance || (res_vld_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command    <= command;
            item_reg.rx_byte    <= rx_byte;
            item_reg.read_index <= read_index;
        end
    end

    ahfr_deframer u_deframer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result)
    );

    assign result_valid = res_vld_reg;
    assign status       = result.status;
    assign frame_ready  = result.frame_ready;
    assign frame_length = result.frame_length;
    assign read_data    = result.read_data;

endmodule
`default_nettype wire

### hw/rtl/ahfr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ahfr_checker
// Port-level checks of the HDLC receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ahfr_checker
    import ahfr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [1:0] status,
    input wire logic       frame_ready,
    input wire logic [7:0] frame_length,
    input wire logic [7:0] read_data
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status) &&
        $stable(frame_ready) && $stable(frame_length) && $stable(read_data))
        else $error("result changed while stalled");

    a_len_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !frame_ready |-> frame_length == 8'h00)
        else $error("frame_length nonzero without a ready frame");

    a_latched_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_LATCHED || status == ST_REJECT) |-> frame_ready)
        else $error("latched or rejected status without a ready frame");

    a_overflow_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OVERFLOW |-> !frame_ready)
        else $error("overflow reported while a frame is ready");

endmodule

bind async_hdlc_frame_receiver ahfr_checker u_ahfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .frame_ready  (frame_ready),
    .frame_length (frame_length),
    .read_data    (read_data)
);
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HDLC frame receiver.
// The block is fed byte-stuffed frames with good and bad CRCs, aborts, stored
// byte reads, releases and line noise. Both channels idle at random. Every
// result is checked against an in-bench prediction of the deframer.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ahfr_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 60;
    localparam int         IDLE_PCT     = 22;
    localparam int         CALM_FROM    = 300;
    localparam int         CALM_TO      = 450;
    localparam int         QUIET_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 20;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    logic [1:0] command      = CMD_FEED;
    logic [7:0] rx_byte      = 8'h00;
    logic [7:0] read_index   = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [1:0] status;
    logic       frame_ready;
    logic [7:0] frame_length;
    logic [7:0] read_data;

    // predicted receiver state
    logic [7:0]  store_copy [STORE_DEPTH];
    int unsigned held_count = 0;
    logic [15:0] frame_crc  = CRC_INIT;
    bit          esc_seen   = 1'b0;
    bit          frame_held = 1'b0;
    int unsigned frame_len  = 0;
    logic [7:0]  byte_n1    = 8'h00;
    logic [7:0]  byte_n2    = 8'h00;

    ahfr_item_t   outgoing_items [$];
    ahfr_result_t expected_responses [$];
    logic [7:0]   payload_q [$];
    ahfr_item_t   staged;
    ahfr_result_t want;
    ahfr_result_t got_pred;

    int  items_accepted  = 0;
    int  results_checked = 0;
    int  error_count     = 0;
    int  latched_seen    = 0;
    int  rejected_seen   = 0;
    int  overflow_seen   = 0;
    int  reads_seen      = 0;
    int  quiet_cycles    = 0;
    logic calm;

    assign calm = (items_accepted >= CALM_FROM) && (items_accepted < CALM_TO);

    async_hdlc_frame_receiver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .frame_ready  (frame_ready),
        .frame_length (frame_length),
        .read_data    (read_data)
    );

    always #5 clk = ~clk;

    // reflected CRC-16, LSB first
    function automatic logic [15:0] fcs_fold(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ octet[k])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic ahfr_result_t deframe_step(input ahfr_item_t it);
        ahfr_result_t r;
        logic [7:0]   b;
        r = '0;
        r.status = ST_OK;
        b = it.rx_byte;
        case (it.command)
            CMD_FEED:
            begin
                if (frame_held)
                    r.status = ST_REJECT;
                else if (b == FLAG_OCTET)
                begin
                    // flag after an escape aborts; otherwise check the trailing FCS
                    if (esc_seen)
                        esc_seen = 1'b0;
                    else if (held_count >= 2 && frame_crc == {byte_n1, byte_n2})
                    begin
                        frame_len  = held_count - 2;
                        frame_held = 1'b1;
                        r.status   = ST_LATCHED;
                    end
                    held_count = 0;
                    frame_crc  = CRC_INIT;
                end
                else if (!esc_seen && b == ESC_OCTET)
                    esc_seen = 1'b1;
                else
                begin
                    if (esc_seen)
                    begin
                        b        = b ^ FLIP_BIT;
                        esc_seen = 1'b0;
                    end
                    store_copy[held_count] = b;
                    // CRC lags two bytes so the FCS itself is never folded in
                    if (held_count >= 2)
                        frame_crc = fcs_fold(frame_crc, byte_n2);
                    byte_n2 = byte_n1;
                    byte_n1 = b;
                    held_count++;
                    if (held_count >= STORE_DEPTH)
                    begin
                        held_count = 0;
                        frame_crc  = CRC_INIT;
                        r.status   = ST_OVERFLOW;
                    end
                end
            end
            CMD_READ:
            begin
                if (it.read_index < STORE_DEPTH)
                    r.read_data = store_copy[it.read_index];
            end
            CMD_RELEASE:
            begin
                held_count = 0;
                frame_crc  = CRC_INIT;
                esc_seen   = 1'b0;
                frame_held = 1'b0;
                frame_len  = 0;
            end
            default:
            begin
            end
        endcase
        r.frame_ready  = frame_held;
        r.frame_length = !frame_held ? 8'h00 : (frame_len > 255) ? 8'hFF : 8'(frame_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_checked, what);
        error_count++;
    endtask

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] idx);
        ahfr_item_t it;
        it.command    = cmd;
        it.rx_byte    = b;
        it.read_index = idx;
        outgoing_items.push_back(it);
    endtask

    task automatic send_octet(input logic [7:0] b);
        if (b == FLAG_OCTET || b == ESC_OCTET)
        begin
            push_item(CMD_FEED, ESC_OCTET, 8'($urandom));
            push_item(CMD_FEED, b ^ FLIP_BIT, 8'($urandom));
        end
        else
            push_item(CMD_FEED, b, 8'($urandom));
    endtask

    task automatic fill_payload(input int len);
        int pick;
        payload_q.delete();
        repeat (len)
        begin
            pick = $urandom_range(15);
            payload_q.push_back(pick == 0 ? FLAG_OCTET : pick == 1 ? ESC_OCTET : 8'($urandom));
        end
    endtask

    // payload_q, then FCS low byte first (or an abort escape), then closing flag
    task automatic send_frame(input logic [15:0] fcs_flip, input bit do_abort);
        logic [15:0] fcs;
        fcs = CRC_INIT;
        foreach (payload_q[i])
        begin
            fcs = fcs_fold(fcs, payload_q[i]);
            send_octet(payload_q[i]);
        end
        fcs = fcs ^ fcs_flip;
        if (do_abort)
            push_item(CMD_FEED, ESC_OCTET, 8'($urandom));
        else
        begin
            send_octet(fcs[7:0]);
            send_octet(fcs[15:8]);
        end
        push_item(CMD_FEED, FLAG_OCTET, 8'($urandom));
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                got_pred = deframe_step(ahfr_item_t'({command, rx_byte, read_index}));
                expected_responses.push_back(got_pred);
                items_accepted++;
                if (got_pred.status == ST_LATCHED)
                    latched_seen++;
                if (got_pred.status == ST_REJECT)
                    rejected_seen++;
                if (got_pred.status == ST_OVERFLOW)
                    overflow_seen++;
                if (command == CMD_READ)
                    reads_seen++;
            end
            if (!item_valid || !item_stall)
            begin
                if (outgoing_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    staged = outgoing_items.pop_front();
                    item_valid <= 1'b1;
                    command    <= staged.command;
                    rx_byte    <= staged.rx_byte;
                    read_index <= staged.read_index;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            if (result_valid && !result_stall)
            begin
                if (expected_responses.size() == 0)
                    report_mismatch($sformatf("result with nothing expected, status %0d", status));
                else
                begin
                    want = expected_responses.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (frame_ready !== want.frame_ready)
                        report_mismatch($sformatf("frame_ready %0d, expected %0d",
                                                  frame_ready, want.frame_ready));
                    if (frame_length !== want.frame_length)
                        report_mismatch($sformatf("frame_length %0d, expected %0d",
                                                  frame_length, want.frame_length));
                    if (read_data !== want.read_data)
                        report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                                  read_data, want.read_data));
                end
                results_checked++;
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0]  b;
        logic [15:0] flip;
        int          pick;
        int          len;
        int          goal;

        // Fill the whole store with one over-long frame; this also hits the overflow.
        repeat (STORE_DEPTH)
        begin
            do
                b = 8'($urandom);
            while (b == FLAG_OCTET || b == ESC_OCTET);
            push_item(CMD_FEED, b, 8'($urandom));
        end

        // directed cases
        push_item(CMD_FEED, FLAG_OCTET, 8'h00);
        push_item(CMD_FEED, ESC_OCTET, 8'hFF);      // flag during escape
        push_item(CMD_FEED, FLAG_OCTET, 8'h00);
        push_item(CMD_FEED, 8'h41, 8'h00);          // too short to hold an FCS
        push_item(CMD_FEED, FLAG_OCTET, 8'h00);
        push_item(CMD_FEED, ESC_OCTET, 8'h00);      // escaped ordinary byte
        push_item(CMD_FEED, 8'h41, 8'h00);
        push_item(CMD_FEED, FLAG_OCTET, 8'h00);
        payload_q.delete();
        send_frame(16'h0000, 1'b0);                 // empty payload, FCS only
        push_item(CMD_FEED, 8'h41, 8'h00);          // rejected while pending
        push_item(CMD_FEED, FLAG_OCTET, 8'h00);
        push_item(CMD_READ, 8'hFF, 8'h00);
        push_item(CMD_READ, 8'h00, 8'h01);
        push_item(CMD_RELEASE, 8'h00, 8'h00);
        push_item(CMD_UNUSED, 8'hFF, 8'hFF);
        payload_q = '{FLAG_OCTET, ESC_OCTET, 8'h00, 8'hFF};
        send_frame(16'h0000, 1'b0);
        for (int i = 0; i < 4; i++)
            push_item(CMD_READ, 8'h00, 8'(i));
        push_item(CMD_RELEASE, 8'hFF, 8'hFF);
        fill_payload(3);
        send_frame(16'h0001, 1'b0);                 // bad CRC
        fill_payload(STORE_DEPTH - 3);              // longest frame that fits
        send_frame(16'h0000, 1'b0);
        for (int i = STORE_DEPTH - 4; i < STORE_DEPTH; i++)
            push_item(CMD_READ, 8'h00, 8'(i));
        push_item(CMD_RELEASE, 8'h00, 8'h00);

        // random traffic, mostly well-formed frames
        goal = outgoing_items.size() + RANDOM_ITEMS;
        while (outgoing_items.size() < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(1) == 0)
                    push_item(CMD_FEED, FLAG_OCTET, 8'($urandom));
                len = ($urandom_range(39) == 0) ? $urandom_range(13, STORE_DEPTH - 2)
                                                : $urandom_range(0, 12);
                fill_payload(len);
                flip = ($urandom_range(6) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
                send_frame(flip, $urandom_range(19) == 0);
                repeat ($urandom_range(3))
                    push_item(CMD_READ, 8'($urandom), 8'($urandom));
                if ($urandom_range(3) == 0)
                    push_item(CMD_FEED, 8'($urandom), 8'($urandom));
                if ($urandom_range(99) < 85)
                    push_item(CMD_RELEASE, 8'($urandom), 8'($urandom));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    len = $urandom_range(7);
                    b = (len == 0) ? FLAG_OCTET : (len == 1) ? ESC_OCTET : 8'($urandom);
                    push_item(CMD_FEED, b, 8'($urandom));
                end
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 4))
                    push_item(CMD_READ, 8'($urandom), 8'($urandom));
            end
            else
                push_item($urandom_range(1) ? CMD_UNUSED : CMD_RELEASE,
                          8'($urandom), 8'($urandom));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while ((outgoing_items.size() != 0 || item_valid || expected_responses.size() != 0)
               && quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        if (quiet_cycles < QUIET_LIMIT)
            repeat (DRAIN_CYCLES) @(posedge clk);
        else
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        if (expected_responses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_responses.size()));

        $display("Sent %0d transactions and checked %0d results.",
                 items_accepted, results_checked);
        $display("Frames latched %0d, feeds rejected %0d, overflows %0d, store reads %0d.",
                 latched_seen, rejected_seen, overflow_seen, reads_seen);
        if (quiet_cycles < QUIET_LIMIT && error_count == 0)
            $display("async_hdlc_frame_receiver test passed");
        else
            $display("async_hdlc_frame_receiver test failed");
        $finish;
    end

endmodule

### async_hdlc_frame_receiver.f
hw/rtl/ahfr_pkg.sv
hw/rtl/ahfr_deframer.sv
hw/rtl/async_hdlc_frame_receiver.sv
hw/rtl/ahfr_checker.sv
test/testbench.sv
